// ----- hw/rtl/pst_pkg.sv -----
// types and constants shared by the packet sequence ack tracker
package pst_pkg;

    localparam int TAG_W       = 32;
    localparam int MAX_RESULTS = 16;
    localparam int RES_CW      = $clog2(MAX_RESULTS + 1);

    typedef logic [1:0]       t_cmd;
    typedef logic [3:0]       t_kind;
    typedef logic [TAG_W-1:0] t_tag;

    localparam t_cmd CMD_RECV  = 2'd0;
    localparam t_cmd CMD_SEND  = 2'd1;
    localparam t_cmd CMD_ACK   = 2'd2;
    localparam t_cmd CMD_FLUSH = 2'd3;

    localparam t_kind K_IN_ORDER   = 4'd0;
    localparam t_kind K_GAP        = 4'd1;
    localparam t_kind K_DROPPED    = 4'd2;
    localparam t_kind K_ACK_ONLY   = 4'd3;
    localparam t_kind K_DELIVERED  = 4'd4;
    localparam t_kind K_LOST       = 4'd5;
    localparam t_kind K_ACK_SEND   = 4'd6;
    localparam t_kind K_REGISTERED = 4'd7;
    localparam t_kind K_FULL       = 4'd8;
    localparam t_kind K_NOTHING    = 4'd9;

    typedef struct packed {
        logic push;
        logic pop;
        logic rd;
    } t_ring_op;

    typedef struct packed {
        logic empty;
        logic full;
        logic one;
    } t_ring_sts;

    typedef struct packed {
        logic eq;
        logic lt;
    } t_cmp_res;

endpackage

// ----- hw/rtl/pst_ring.sv -----
// circular tag queue with one write port and a registered head read
module pst_ring #(
    parameter int DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pst_pkg::t_ring_op   i_op,
    input  pst_pkg::t_tag       i_wdata,
    output pst_pkg::t_tag       o_rdata,
    output pst_pkg::t_ring_sts  o_sts
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    pst_pkg::t_tag r_mem [DEPTH];
    pst_pkg::t_tag r_rdata;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_op.push) begin
            n_tail = (r_tail == AW'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
        end
        if (i_op.pop) begin
            n_head = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
        end
        if (i_op.push && !i_op.pop) begin
            n_count = r_count + 1'b1;
        end else if (i_op.pop && !i_op.push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.push) begin
            r_mem[r_tail] <= i_wdata;
        end
        if (i_op.rd) begin
            r_rdata <= r_mem[r_head];
        end
    end

    assign o_rdata     = r_rdata;
    assign o_sts.empty = (r_count == '0);
    assign o_sts.full  = (r_count == CW'(DEPTH));
    assign o_sts.one   = (r_count == CW'(1));

endmodule

// ----- hw/rtl/pst_cmp.sv -----
// shared unsigned tag comparator
module pst_cmp (
    input  pst_pkg::t_tag     i_a,
    input  pst_pkg::t_tag     i_b,
    output pst_pkg::t_cmp_res o_res
);

    assign o_res.eq = (i_a == i_b);
    assign o_res.lt = (i_a < i_b);

endmodule

// ----- hw/rtl/packet_sequence_ack_tracker.sv -----
// Tracks receive sequencing, pending acks and the in-flight queue of one link side.
// Input ready is high only while the sequencer is idle. Receive and register commands
// pass an accept state, then a dispatch state that loads the result into the output
// register. An incoming ack passes the accept and dispatch states, then walks the
// in-flight queue one entry at a time (head read, then compare and retire), up to 16
// entries, then emits the last result. A flush passes the accept and dispatch states,
// then emits the pending acks one at a time (read, emit), up to 16 per command. All tag
// compares go through one shared comparator; both queues are memories with one write
// port and a registered head read. Each result waits for the output register to drain,
// so output stalls hold the sequencer back.
module packet_sequence_ack_tracker #(
    parameter int PENDING_DEPTH   = 16,
    parameter int IN_FLIGHT_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_tag,
    input  logic        i_ack_only,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_kind,
    output logic [31:0] o_result_tag,
    output logic        o_pending_overflow,
    output logic        o_last
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_RET  = 3'd3;
    localparam logic [2:0] S_LAST = 3'd4;
    localparam logic [2:0] S_FRD  = 3'd5;
    localparam logic [2:0] S_FOUT = 3'd6;

    logic [2:0] r_state, n_state;

    pst_pkg::t_cmd  r_cmd;
    pst_pkg::t_tag  r_tag;
    logic           r_ack_only;
    pst_pkg::t_tag  r_exp, n_exp;
    logic [pst_pkg::RES_CW-1:0] r_n, n_n;
    logic           r_have, n_have;
    pst_pkg::t_kind r_hold_kind, n_hold_kind;
    pst_pkg::t_tag  r_hold_tag, n_hold_tag;

    logic           r_out_valid;
    pst_pkg::t_kind r_kind;
    pst_pkg::t_tag  r_rtag;
    logic           r_ovf;
    logic           r_last;

    logic           e_valid;
    pst_pkg::t_kind e_kind;
    pst_pkg::t_tag  e_tag;
    logic           e_ovf;
    logic           e_last;

    pst_pkg::t_ring_op  pa_op, if_op;
    pst_pkg::t_ring_sts pa_sts, if_sts;
    pst_pkg::t_tag      pa_rdata, if_rdata;
    pst_pkg::t_tag      cmp_b;
    pst_pkg::t_cmp_res  cmp_res;
    logic               at_max;

    pst_ring #(.DEPTH(PENDING_DEPTH)) u_pending (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (pa_op),
        .i_wdata (r_tag),
        .o_rdata (pa_rdata),
        .o_sts   (pa_sts)
    );

    pst_ring #(.DEPTH(IN_FLIGHT_DEPTH)) u_in_flight (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (if_op),
        .i_wdata (r_tag),
        .o_rdata (if_rdata),
        .o_sts   (if_sts)
    );

    assign cmp_b = (r_state == S_RET) ? if_rdata : r_exp;

    pst_cmp u_cmp (
        .i_a   (r_tag),
        .i_b   (cmp_b),
        .o_res (cmp_res)
    );

    assign at_max     = (r_n == pst_pkg::RES_CW'(pst_pkg::MAX_RESULTS - 1));
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_exp       = r_exp;
        n_n         = r_n;
        n_have      = r_have;
        n_hold_kind = r_hold_kind;
        n_hold_tag  = r_hold_tag;
        e_valid     = 1'b0;
        e_kind      = pst_pkg::K_NOTHING;
        e_tag       = '0;
        e_ovf       = 1'b0;
        e_last      = 1'b0;
        pa_op       = '0;
        if_op       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (!r_out_valid) begin
                    case (r_cmd)
                        pst_pkg::CMD_RECV: begin
                            e_valid = 1'b1;
                            e_last  = 1'b1;
                            e_tag   = r_tag;
                            n_state = S_IDLE;
                            if (r_ack_only) begin
                                e_kind = pst_pkg::K_ACK_ONLY;
                            end else if (cmp_res.lt) begin
                                e_kind = pst_pkg::K_DROPPED;
                            end else begin
                                e_kind = cmp_res.eq ? pst_pkg::K_IN_ORDER : pst_pkg::K_GAP;
                                n_exp  = r_tag + 1'b1;
                                if (pa_sts.full) begin
                                    e_ovf = 1'b1;
                                end else begin
                                    pa_op.push = 1'b1;
                                end
                            end
                        end
                        pst_pkg::CMD_SEND: begin
                            e_valid = 1'b1;
                            e_last  = 1'b1;
                            n_state = S_IDLE;
                            if (r_ack_only) begin
                                e_kind = pst_pkg::K_NOTHING;
                            end else if (if_sts.full) begin
                                e_kind = pst_pkg::K_FULL;
                                e_tag  = r_tag;
                            end else begin
                                e_kind     = pst_pkg::K_REGISTERED;
                                e_tag      = r_tag;
                                if_op.push = 1'b1;
                            end
                        end
                        pst_pkg::CMD_ACK: begin
                            n_n    = '0;
                            n_have = 1'b0;
                            if (if_sts.empty) begin
                                e_valid = 1'b1;
                                e_last  = 1'b1;
                                n_state = S_IDLE;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        default: begin
                            n_n = '0;
                            if (pa_sts.empty) begin
                                e_valid = 1'b1;
                                e_last  = 1'b1;
                                n_state = S_IDLE;
                            end else begin
                                n_state = S_FRD;
                            end
                        end
                    endcase
                end
            end
            S_RD: begin
                if_op.rd = 1'b1;
                n_state  = S_RET;
            end
            S_RET: begin
                if (!r_out_valid) begin
                    if (cmp_res.lt) begin
                        e_valid = 1'b1;
                        e_last  = 1'b1;
                        if (r_have) begin
                            e_kind = r_hold_kind;
                            e_tag  = r_hold_tag;
                        end
                        n_state = S_IDLE;
                    end else begin
                        if (r_have) begin
                            e_valid = 1'b1;
                            e_kind  = r_hold_kind;
                            e_tag   = r_hold_tag;
                        end
                        n_have      = 1'b1;
                        n_hold_kind = cmp_res.eq ? pst_pkg::K_DELIVERED : pst_pkg::K_LOST;
                        n_hold_tag  = if_rdata;
                        if_op.pop   = 1'b1;
                        n_n         = r_n + 1'b1;
                        if (cmp_res.eq || if_sts.one || at_max) begin
                            n_state = S_LAST;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                end
            end
            S_LAST: begin
                if (!r_out_valid) begin
                    e_valid = 1'b1;
                    e_last  = 1'b1;
                    e_kind  = r_hold_kind;
                    e_tag   = r_hold_tag;
                    n_state = S_IDLE;
                end
            end
            S_FRD: begin
                pa_op.rd = 1'b1;
                n_state  = S_FOUT;
            end
            S_FOUT: begin
                if (!r_out_valid) begin
                    e_valid   = 1'b1;
                    e_kind    = pst_pkg::K_ACK_SEND;
                    e_tag     = pa_rdata;
                    e_last    = pa_sts.one || at_max;
                    pa_op.pop = 1'b1;
                    n_n       = r_n + 1'b1;
                    n_state   = (pa_sts.one || at_max) ? S_IDLE : S_FRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_exp       <= '0;
            r_n         <= '0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_exp   <= n_exp;
            r_n     <= n_n;
            r_have  <= n_have;
            if (e_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_cmd      <= i_command;
            r_tag      <= i_tag;
            r_ack_only <= i_ack_only;
        end
        r_hold_kind <= n_hold_kind;
        r_hold_tag  <= n_hold_tag;
        if (e_valid) begin
            r_kind <= e_kind;
            r_rtag <= e_tag;
            r_ovf  <= e_ovf;
            r_last <= e_last;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_kind             = r_kind;
    assign o_result_tag       = r_rtag;
    assign o_pending_overflow = r_ovf;
    assign o_last             = r_last;

    a_res_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= pst_pkg::RES_CW'(pst_pkg::MAX_RESULTS))
        else $error("retire count beyond limit");

    a_flush_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (e_valid && e_kind == pst_pkg::K_ACK_SEND) |-> !pa_sts.empty)
        else $error("ack emitted from empty pending queue");

    a_retire_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        if_op.pop |-> !if_sts.empty)
        else $error("retire from empty in-flight queue");

    a_ovf_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pending_overflow) |->
            (o_kind == pst_pkg::K_IN_ORDER || o_kind == pst_pkg::K_GAP))
        else $error("overflow flag on non-accept result");

endmodule
